@@ hdl/i2cs_pkg.sv @@
// i2cs_pkg: shared types and constants for the servo register slave
// used by i2cs_regbank, i2cs_pulse and i2c_register_slave_servo_pulse
package i2cs_pkg;

	localparam int REG_SLOTS = 16;
	localparam int IDX_W     = $clog2(REG_SLOTS);
	localparam int PTR_W     = 8;

	localparam logic [IDX_W-1:0] SLOT_STEER  = IDX_W'(0);
	localparam logic [IDX_W-1:0] SLOT_POWER  = IDX_W'(1);
	localparam logic [IDX_W-1:0] SLOT_STATUS = IDX_W'(2);
	localparam logic [IDX_W-1:0] SLOT_ID     = IDX_W'(REG_SLOTS - 1);

	localparam logic [7:0]  STEER_RST     = 8'd128;
	localparam logic [7:0]  POWER_RST     = 8'd128;
	localparam logic [7:0]  STATUS_RST    = 8'h01;
	localparam logic [7:0]  DEVICE_ID_RST = 8'h42;
	localparam logic [7:0]  OOR_DATA      = 8'hFF;
	localparam logic [14:0] CENTER_RST    = 15'd1470;
	localparam logic [9:0]  SPAN_RST      = 10'd200;
	localparam logic [14:0] PULSE_MAX     = 15'd20000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd2;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_READ = 2'd1,
		CMD_END  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] cmd;
		logic [7:0] rx;
	} item_t;

	typedef struct packed {
		logic       we;
		logic [7:0] data;
	} id_wr_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       rvalid;
		logic       done;
		logic [7:0] steer;
		logic [7:0] power;
	} bank_res_t;

	function automatic logic [7:0] slot_reset(input int i);
		logic [7:0] v;
		v = 8'd0;
		if (i == int'(SLOT_STEER))  v = STEER_RST;
		if (i == int'(SLOT_POWER))  v = POWER_RST;
		if (i == int'(SLOT_STATUS)) v = STATUS_RST;
		if (i == int'(SLOT_ID))     v = DEVICE_ID_RST;
		return v;
	endfunction

endpackage

@@ hdl/i2c_register_slave_servo_pulse.sv @@
// i2c_register_slave_servo_pulse: top level, input and result registers, config
// depends on i2cs_pkg, i2cs_regbank, i2cs_pulse
//
// One bus event is taken in every clock cycle; busy never rises. An event is
// captured into the input register and executed against the register bank in the
// following cycle. Its result is registered at the next clock edge and sits on the
// result ports with strobe high for one cycle. Results cannot be held off.
// Configuration writes are taken at once (cfg_ready stays high); writing the
// identity value also reloads the identity register of the bank.
module i2c_register_slave_servo_pulse (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output logic        strobe,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        transaction_done,
	output logic [14:0] steering_pulse_us,
	output logic [7:0]  power_setting
);

	logic                vld_s1;
	logic [1:0]          cmd_s1;
	logic [7:0]          rx_s1;
	logic                strobe_s2;
	logic [7:0]          rdata_s2;
	logic                rvalid_s2;
	logic                done_s2;
	logic [14:0]         pulse_s2;
	logic [7:0]          power_s2;
	logic [14:0]         center_q;
	logic [9:0]          span_q;
	logic                cfg_we;
	i2cs_pkg::item_t     item;
	i2cs_pkg::id_wr_t    id_wr;
	i2cs_pkg::bank_res_t res;
	logic [14:0]         pulse;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign item.vld   = vld_s1;
	assign item.cmd   = cmd_s1;
	assign item.rx    = rx_s1;
	assign id_wr.we   = cfg_we && (cfg_index == i2cs_pkg::CFG_DEVICE_ID);
	assign id_wr.data = cfg_data[7:0];

	i2cs_regbank u_regbank (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.id_wr  (id_wr),
		.res    (res)
	);

	i2cs_pulse u_pulse (
		.steer  (res.steer),
		.center (center_q),
		.span   (span_q),
		.pulse  (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			strobe_s2 <= 1'b0;
			center_q  <= i2cs_pkg::CENTER_RST;
			span_q    <= i2cs_pkg::SPAN_RST;
		end else begin
			vld_s1    <= start && !busy;
			strobe_s2 <= vld_s1;
			if (cfg_we) begin
				unique case (cfg_index)
					i2cs_pkg::CFG_CENTER: center_q <= cfg_data;
					i2cs_pkg::CFG_SPAN:   span_q   <= cfg_data[9:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
			rx_s1  <= rx_byte;
		end
		if (vld_s1) begin
			rdata_s2  <= res.rdata;
			rvalid_s2 <= res.rvalid;
			done_s2   <= res.done;
			pulse_s2  <= pulse;
			power_s2  <= res.power;
		end
	end

	assign strobe            = strobe_s2;
	assign read_data         = rdata_s2;
	assign read_valid        = rvalid_s2;
	assign transaction_done  = done_s2;
	assign steering_pulse_us = pulse_s2;
	assign power_setting     = power_s2;

endmodule

@@ hdl/i2cs_regbank.sv @@
// i2cs_regbank: register bank, pointer and capture flag; executes one bus event
// depends on i2cs_pkg
module i2cs_regbank (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cs_pkg::item_t     item,
	input  i2cs_pkg::id_wr_t    id_wr,
	output i2cs_pkg::bank_res_t res
);

	logic [7:0]                     bank_q [i2cs_pkg::REG_SLOTS];
	logic [i2cs_pkg::PTR_W-1:0]     ptr_q;
	logic                           loaded_q;
	logic [i2cs_pkg::IDX_W-1:0]     idx;
	logic                           in_range;
	logic                           writable;
	logic                           wr_en;
	logic                           ptr_load;
	logic                           ptr_inc;
	logic                           clr_loaded;

	assign idx      = ptr_q[i2cs_pkg::IDX_W-1:0];
	assign in_range = ({1'b0, ptr_q} < 9'(i2cs_pkg::REG_SLOTS));
	assign writable = in_range && (idx != i2cs_pkg::SLOT_STATUS) && (idx != i2cs_pkg::SLOT_ID);

	always_comb begin
		wr_en      = 1'b0;
		ptr_load   = 1'b0;
		ptr_inc    = 1'b0;
		clr_loaded = 1'b0;
		res.rdata  = 8'd0;
		res.rvalid = 1'b0;
		res.done   = 1'b0;
		if (item.vld) begin
			unique case (item.cmd)
				i2cs_pkg::CMD_BYTE: begin
					if (!loaded_q) begin
						ptr_load = 1'b1;
					end else begin
						wr_en   = writable;
						ptr_inc = 1'b1;
					end
				end
				i2cs_pkg::CMD_READ: begin
					res.rdata  = in_range ? bank_q[idx] : i2cs_pkg::OOR_DATA;
					res.rvalid = 1'b1;
					ptr_inc    = 1'b1;
				end
				i2cs_pkg::CMD_END: begin
					clr_loaded = 1'b1;
					res.done   = 1'b1;
				end
				default: begin
				end
			endcase
		end
		res.steer = (wr_en && idx == i2cs_pkg::SLOT_STEER) ? item.rx
		                                                    : bank_q[i2cs_pkg::SLOT_STEER];
		res.power = (wr_en && idx == i2cs_pkg::SLOT_POWER) ? item.rx
		                                                    : bank_q[i2cs_pkg::SLOT_POWER];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < i2cs_pkg::REG_SLOTS; i++) begin
				bank_q[i] <= i2cs_pkg::slot_reset(i);
			end
			ptr_q    <= '0;
			loaded_q <= 1'b0;
		end else begin
			for (int i = 0; i < i2cs_pkg::REG_SLOTS; i++) begin
				if (wr_en && idx == i2cs_pkg::IDX_W'(i)) begin
					bank_q[i] <= item.rx;
				end
			end
			if (id_wr.we) begin
				bank_q[i2cs_pkg::SLOT_ID] <= id_wr.data;
			end
			if (ptr_load) begin
				ptr_q    <= item.rx;
				loaded_q <= 1'b1;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + 8'd1;
			end
			if (clr_loaded) begin
				loaded_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/i2cs_pulse.sv @@
// i2cs_pulse: servo pulse width from steering byte, center and span
// depends on i2cs_pkg
module i2cs_pulse (
	input  logic [7:0]  steer,
	input  logic [14:0] center,
	input  logic [9:0]  span,
	output logic [14:0] pulse
);

	logic signed [8:0]  diff;
	logic signed [19:0] prod;
	logic signed [19:0] prod_adj;
	logic signed [12:0] quot;
	logic signed [16:0] raw;

	assign diff     = $signed({1'b0, steer}) - 9'sd128;
	assign prod     = diff * $signed({1'b0, span});
	// bias negatives so the shift truncates toward zero
	assign prod_adj = prod + (prod[19] ? 20'sd127 : 20'sd0);
	assign quot     = prod_adj[19:7];
	assign raw      = $signed({2'b00, center}) - $signed({{4{quot[12]}}, quot});

	always_comb begin
		priority if (raw[16]) begin
			pulse = 15'd0;
		end else if (raw[15:0] > {1'b0, i2cs_pkg::PULSE_MAX}) begin
			pulse = i2cs_pkg::PULSE_MAX;
		end else begin
			pulse = raw[14:0];
		end
	end

endmodule

@@ test/servo_bank_checker.sv @@
// servo_bank_checker: watches the bus event, result and setting channels of the
// servo register slave, predicts every result and compares field by field
// depends on i2cs_pkg only
module servo_bank_checker
	import i2cs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        strobe,
	input  logic [7:0]  read_data,
	input  logic        read_valid,
	input  logic        transaction_done,
	input  logic [14:0] steering_pulse_us,
	input  logic [7:0]  power_setting,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEER_MID = 128;

	typedef struct {
		logic [7:0]  rdata;
		logic        rvalid;
		logic        done;
		logic [14:0] pulse;
		logic [7:0]  power;
	} reply_t;

	logic [7:0]  bank [REG_SLOTS];
	logic [7:0]  ptr;
	logic        ptr_loaded;
	logic [14:0] center;
	logic [9:0]  span;
	reply_t      pending_replies [$];
	int          mismatches = 0;
	int          waiting = 0;

	assign errors      = mismatches;
	assign outstanding = waiting;

	task automatic predict_bus_event(input logic [1:0] c, input logic [7:0] b,
			output reply_t r);
		int p;
		int d;
		int q;
		int w;
		p = int'(ptr);
		r.rdata  = 8'd0;
		r.rvalid = 1'b0;
		r.done   = 1'b0;
		case (c)
			CMD_BYTE: begin
				if (!ptr_loaded) begin
					ptr        = b;
					ptr_loaded = 1'b1;
				end else begin
					if (p < REG_SLOTS && p != int'(SLOT_STATUS) && p != int'(SLOT_ID))
						bank[p] = b;
					ptr = ptr + 8'd1;
				end
			end
			CMD_READ: begin
				r.rdata  = (p < REG_SLOTS) ? bank[p] : OOR_DATA;
				r.rvalid = 1'b1;
				ptr      = ptr + 8'd1;
			end
			CMD_END: begin
				ptr_loaded = 1'b0;
				r.done     = 1'b1;
			end
			default: ;
		endcase
		// signed division truncates toward zero
		d = int'(bank[SLOT_STEER]) - STEER_MID;
		q = (d * int'(span)) / 128;
		w = int'(center) - q;
		if (w < 0) w = 0;
		if (w > int'(PULSE_MAX)) w = int'(PULSE_MAX);
		r.pulse = w[14:0];
		r.power = bank[SLOT_POWER];
	endtask

	task automatic check_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < REG_SLOTS; i++)
				bank[i] = 8'd0;
			bank[SLOT_STEER]  = STEER_RST;
			bank[SLOT_POWER]  = POWER_RST;
			bank[SLOT_STATUS] = STATUS_RST;
			bank[SLOT_ID]     = DEVICE_ID_RST;
			ptr        = 8'd0;
			ptr_loaded = 1'b0;
			center     = CENTER_RST;
			span       = SPAN_RST;
			pending_replies.delete();
			waiting = 0;
		end else begin
			if (strobe) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: result word with no event waiting, expected none, actual %0d/%0d",
						$time, read_data, steering_pulse_us);
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					check_field("read_data", want.rdata, read_data);
					check_field("read_valid", want.rvalid, read_valid);
					check_field("transaction_done", want.done, transaction_done);
					check_field("steering_pulse_us", want.pulse, steering_pulse_us);
					check_field("power_setting", want.power, power_setting);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CENTER:    center = cfg_data;
					CFG_SPAN:      span = cfg_data[9:0];
					CFG_DEVICE_ID: bank[SLOT_ID] = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				predict_bus_event(cmd, rx_byte, want);
				pending_replies.push_back(want);
			end
			waiting = pending_replies.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// testbench: drives bus events and setting writes into the servo register slave,
// directed corner cases first, then random transactions under several settings
// depends on i2cs_pkg, i2c_register_slave_servo_pulse and servo_bank_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET    = 750;
	localparam int PHASES         = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_LIMIT    = 200;
	localparam int SETTLE_CYCLES  = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = CMD_BYTE;
	logic [7:0]  rx_byte = 8'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_CENTER;
	logic [14:0] cfg_data = 15'd0;
	logic        strobe;
	logic [7:0]  read_data;
	logic        read_valid;
	logic        transaction_done;
	logic [14:0] steering_pulse_us;
	logic [7:0]  power_setting;
	int          errors;
	int          outstanding;

	int words_sent = 0;
	int burst_left = 0;
	int quiet_cycles = 0;

	i2c_register_slave_servo_pulse dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.rx_byte           (rx_byte),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.strobe            (strobe),
		.read_data         (read_data),
		.read_valid        (read_valid),
		.transaction_done  (transaction_done),
		.steering_pulse_us (steering_pulse_us),
		.power_setting     (power_setting)
	);

	servo_bank_checker bank_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.rx_byte           (rx_byte),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.strobe            (strobe),
		.read_data         (read_data),
		.read_valid        (read_valid),
		.transaction_done  (transaction_done),
		.steering_pulse_us (steering_pulse_us),
		.power_setting     (power_setting),
		.errors            (errors),
		.outstanding       (outstanding)
	);

	always begin
		#2;
		clk = 1'b1;
		#2;
		clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of back-to-back words separated by random gaps
	task automatic send_word(input logic [1:0] c, input logic [7:0] b);
		if (burst_left == 0) begin
			pause($urandom_range(1, 12));
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		start   <= 1'b1;
		cmd     <= c;
		rx_byte <= b;
		do @(posedge clk); while (busy);
		if (c != CMD_UNUSED)
			words_sent++;
	endtask

	task automatic drain_replies();
		int waited;
		waited = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (outstanding != 0 && waited < DRAIN_LIMIT);
		@(posedge clk);
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [14:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input int center_us, input int span_us, input int id);
		drain_replies();
		write_setting(CFG_CENTER, 15'(center_us));
		write_setting(CFG_SPAN, 15'(span_us));
		write_setting(CFG_DEVICE_ID, 15'(id));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_pointer();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 8'($urandom_range(0, 1));
		if (r < 7)
			return 8'($urandom_range(0, REG_SLOTS + 1));
		if (r < 8)
			return 8'($urandom_range(250, 255));
		return 8'($urandom);
	endfunction

	task automatic random_transaction();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		n    = $urandom_range(0, 6);
		if (kind < 4) begin
			send_word(CMD_BYTE, pick_pointer());
			repeat (n) send_word(CMD_BYTE, 8'($urandom));
			send_word(CMD_END, 8'($urandom));
		end else if (kind < 7) begin
			send_word(CMD_BYTE, pick_pointer());
			if ($urandom_range(0, 1))
				send_word(CMD_END, 8'($urandom));
			repeat (n) send_word(CMD_READ, 8'($urandom));
			send_word(CMD_END, 8'($urandom));
		end else if (kind < 8) begin
			// steering extremes to reach both clamps
			send_word(CMD_BYTE, 8'(SLOT_STEER));
			case ($urandom_range(0, 3))
				0: send_word(CMD_BYTE, 8'd0);
				1: send_word(CMD_BYTE, 8'd255);
				default: send_word(CMD_BYTE, 8'($urandom));
			endcase
			send_word(CMD_END, 8'($urandom));
		end else begin
			// noise and broken transactions
			repeat ($urandom_range(1, 5)) send_word(2'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_READ, 8'h00);
		send_word(CMD_END, 8'hFF);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_BYTE, 8'hFF);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_BYTE, 8'h55);
		send_word(CMD_END, 8'h00);
		send_word(CMD_BYTE, 8'(SLOT_STATUS));
		send_word(CMD_READ, 8'h00);
		send_word(CMD_READ, 8'hFF);
		send_word(CMD_END, 8'h00);
		send_word(CMD_BYTE, 8'(SLOT_ID));
		send_word(CMD_BYTE, 8'hAA);
		send_word(CMD_BYTE, 8'hAA);
		send_word(CMD_END, 8'h00);
		send_word(CMD_BYTE, 8'hFE);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_BYTE, 8'h80);
		send_word(CMD_END, 8'h00);
		send_word(CMD_BYTE, 8'hFF);
		send_word(CMD_BYTE, 8'h12);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_END, 8'h00);
		send_word(CMD_UNUSED, 8'hFF);
		send_word(CMD_READ, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;
				1: load_settings(0, 1000, 8'h00);
				2: load_settings(int'(PULSE_MAX), 1000, 8'hFF);
				3: load_settings(int'(PULSE_MAX), 0, 8'h5A);
				default: load_settings($urandom_range(0, int'(PULSE_MAX)),
					$urandom_range(0, 1000), $urandom_range(0, 255));
			endcase
			while (words_sent < ITEM_TARGET * (phase + 1) / PHASES)
				random_transaction();
		end

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
